// File: rtl/lpcp_pkg.sv
// Package for the lidar point camera projection block.
// Holds command codes, register indexes, widths and shared types; no dependencies.
package lpcp_pkg;

  localparam int FRAC_BITS  = 16;
  localparam int MAX_WIDTH  = 1024;
  localparam int MAX_HEIGHT = 1024;
  localparam int COL_W      = $clog2(MAX_WIDTH);
  localparam int ROW_W      = $clog2(MAX_HEIGHT);
  localparam int PIX_AW     = COL_W + ROW_W;
  localparam int COEF_COUNT = 12;
  localparam int QW         = 18;   // quotient bits carried by the divider
  localparam int DW         = 64;   // dividend width

  typedef enum logic [1:0] {
    CMD_PROJECT = 2'd0,
    CMD_COEF    = 2'd1,
    CMD_PIXEL   = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_e;

  typedef enum logic [2:0] {
    REG_WIDTH  = 3'd0,
    REG_HEIGHT = 3'd1,
    REG_MAXFWD = 3'd2,
    REG_MINUP  = 3'd3,
    REG_MARGIN = 3'd4
  } reg_e;

  // Sideband that travels with a point through the pipeline.
  typedef struct packed {
    logic               [31:0] x;
    logic               [31:0] y;
    logic               [31:0] z;
  } point_t;

endpackage

// File: rtl/lidar_point_camera_projection.sv
// Top level of the lidar point camera projection block.
// Depends on lpcp_pkg; holds the coefficient and image memories and the projection pipeline.
//
//  channel | direction | handshake             | payload
//  in      | sink      | in_valid_i/in_ready_o | cmd, point, coef, pixel fields
//  out     | source    | out_valid_o/out_ready_i | point, color, image col/row
//  cfg     | APB slave | psel/penable/pready   | five registers at 4*i
//
// One beat per cycle is accepted while the output is not stalled; a point's result passes
// stage 1, stage 2, the QW radix-2 restoring divider stages and the output stage.
// Reset clears all control, loads register defaults; memories are undefined until written.
// The whole pipeline advances only when its last stage is empty or being taken, so
// a stall on the output holds every stage.
module lidar_point_camera_projection
  import lpcp_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic [1:0]         cmd_i,
  input  logic signed [31:0] point_x_i,
  input  logic signed [31:0] point_y_i,
  input  logic signed [31:0] point_z_i,
  input  logic [3:0]         coef_index_i,
  input  logic signed [31:0] coef_value_i,
  input  logic [9:0]         pixel_col_i,
  input  logic [9:0]         pixel_row_i,
  input  logic [23:0]        pixel_rgb_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] out_x_o,
  output logic signed [31:0] out_y_o,
  output logic signed [31:0] out_z_o,
  output logic [7:0]         red_o,
  output logic [7:0]         green_o,
  output logic [7:0]         blue_o,
  output logic [9:0]         image_col_o,
  output logic [9:0]         image_row_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [4:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);

  // ---------------- configuration ----------------
  logic [10:0] width_q, height_q;
  logic [30:0] maxfwd_q;
  logic signed [31:0] minup_q;
  logic [6:0]  margin_q;
  logic        cfg_wr;
  reg_e        cfg_sel;

  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_sel = reg_e'(paddr[4:2]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= 11'd512;
      height_q <= 11'd612;
      maxfwd_q <= 31'(50 << FRAC_BITS);
      minup_q  <= -32'sd1310720;
      margin_q <= 7'd2;
    end else if (cfg_wr && paddr[1:0] == 2'b00) begin
      unique case (cfg_sel)
        REG_WIDTH:  width_q  <= pwdata[10:0];
        REG_HEIGHT: height_q <= pwdata[10:0];
        REG_MAXFWD: maxfwd_q <= pwdata[30:0];
        REG_MINUP:  minup_q  <= pwdata;
        REG_MARGIN: margin_q <= pwdata[6:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    prdata = '0;
    unique case (cfg_sel)
      REG_WIDTH:  prdata = {21'd0, width_q};
      REG_HEIGHT: prdata = {21'd0, height_q};
      REG_MAXFWD: prdata = {1'b0, maxfwd_q};
      REG_MINUP:  prdata = minup_q;
      REG_MARGIN: prdata = {25'd0, margin_q};
      default:    prdata = '0;
    endcase
  end

  // ---------------- pipeline control ----------------
  logic adv;
  logic in_fire;
  logic last_v;
  assign adv        = !last_v || out_ready_i;
  assign in_ready_o = adv;
  assign in_fire    = in_valid_i && in_ready_o;

  // Coefficients live in flip-flops so all twelve are read at once, nine by the multipliers.
  logic signed [31:0] coef_q [COEF_COUNT];
  always_ff @(posedge clk_i) begin
    if (in_fire && cmd_e'(cmd_i) == CMD_COEF && coef_index_i < 4'(COEF_COUNT))
      coef_q[coef_index_i] <= coef_value_i;
  end

  // Pixel writes travel down the pipeline and reach the image memory at the stage
  // where points read it, so each point sees exactly the writes accepted before it.
  logic [PIX_AW-1:0] wr_a;
  logic              wr_en;
  assign wr_a  = {pixel_row_i[ROW_W-1:0], pixel_col_i[COL_W-1:0]};
  assign wr_en = in_fire && cmd_e'(cmd_i) == CMD_PIXEL;

  // ---------------- stage 1: window test and products ----------------
  logic        s1_v_q;
  logic        s1_pw_q;
  logic [PIX_AW-1:0] s1_pa_q;
  logic [23:0] s1_rgb_q;
  point_t      s1_pt_q;
  logic signed [63:0] s1_p_q [9];
  logic signed [31:0] s1_k_q [3];
  logic        win_ok;
  logic signed [32:0] ay;

  assign ay = point_y_i[31] ? -33'(point_y_i) : 33'(point_y_i);
  assign win_ok = !point_x_i[31] && ({1'b0, point_x_i} <= {2'b0, maxfwd_q}) &&
                  (point_z_i >= minup_q) && (ay <= 33'(point_x_i));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s1_pw_q <= 1'b0;
    end else if (adv) begin
      s1_v_q  <= in_fire && cmd_e'(cmd_i) == CMD_PROJECT && win_ok;
      s1_pw_q <= wr_en;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s1_pt_q  <= '{x: point_x_i, y: point_y_i, z: point_z_i};
      s1_pa_q  <= wr_a;
      s1_rgb_q <= pixel_rgb_i;
      for (int r = 0; r < 3; r++) begin
        s1_p_q[3*r]   <= 64'(coef_q[4*r])   * 64'(point_x_i);
        s1_p_q[3*r+1] <= 64'(coef_q[4*r+1]) * 64'(point_y_i);
        s1_p_q[3*r+2] <= 64'(coef_q[4*r+2]) * 64'(point_z_i);
        s1_k_q[r]     <= coef_q[4*r+3];
      end
    end
  end

  // ---------------- stage 2: row sums ----------------
  logic        s2_v_q;
  logic        s2_pw_q;
  logic [PIX_AW-1:0] s2_pa_q;
  logic [23:0] s2_rgb_q;
  point_t      s2_pt_q;
  logic signed [63:0] s2_sum_q [3];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_v_q  <= 1'b0;
      s2_pw_q <= 1'b0;
    end else if (adv) begin
      s2_v_q  <= s1_v_q;
      s2_pw_q <= s1_pw_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      s2_pt_q  <= s1_pt_q;
      s2_pa_q  <= s1_pa_q;
      s2_rgb_q <= s1_rgb_q;
      for (int r = 0; r < 3; r++)
        s2_sum_q[r] <= 64'(s1_k_q[r]) + (s1_p_q[3*r] >>> FRAC_BITS)
                     + (s1_p_q[3*r+1] >>> FRAC_BITS) + (s1_p_q[3*r+2] >>> FRAC_BITS);
    end
  end

  // ---------------- stage 3: sign handling, divider entry ----------------
  // Quotients that need more than QW bits are out of the image anyway; a flag
  // records that |u| or |v| >= w << QW so the truncated quotient is not trusted.
  typedef struct packed {
    logic              v;
    point_t            pt;
    logic              pw;    // pixel write beat
    logic [PIX_AW-1:0] pa;
    logic [23:0]       rgb;
    logic [DW-1:0]     w;
    logic [DW-1:0]     ru;    // remainders
    logic [DW-1:0]     rv;
    logic [QW-1:0]     qu;
    logic [QW-1:0]     qv;
    logic              nu;    // quotient negative
    logic              nv;
    logic              big;
  } dv_t;

  dv_t dv_q [QW+1];
  dv_t dv_d [QW+1];
  logic [DW-1:0] au, av, wm;
  logic          bigu, bigv;
  logic [DW-1:0] dsh [QW];
  logic          tu [QW];
  logic          tv [QW];

  // The divider resolves one quotient bit per stage for u and for v together.
  always_comb begin
    au = s2_sum_q[0][63] ? DW'(-s2_sum_q[0]) : DW'(s2_sum_q[0]);
    av = s2_sum_q[1][63] ? DW'(-s2_sum_q[1]) : DW'(s2_sum_q[1]);
    wm = DW'(s2_sum_q[2]);
    bigu = (au >> QW) >= wm;
    bigv = (av >> QW) >= wm;

    dv_d[0].v   = s2_v_q && !s2_sum_q[2][63] && (s2_sum_q[2] != 64'sd0);
    dv_d[0].pt  = s2_pt_q;
    dv_d[0].pw  = s2_pw_q;
    dv_d[0].pa  = s2_pa_q;
    dv_d[0].rgb = s2_rgb_q;
    dv_d[0].w   = wm;
    dv_d[0].ru  = au;
    dv_d[0].rv  = av;
    dv_d[0].qu  = '0;
    dv_d[0].qv  = '0;
    dv_d[0].nu  = s2_sum_q[0][63];
    dv_d[0].nv  = s2_sum_q[1][63];
    dv_d[0].big = bigu || bigv;

    for (int g = 0; g < QW; g++) begin
      dsh[g] = dv_q[g].w << (QW - 1 - g);
      tu[g]  = (dv_q[g].ru >> (QW - 1 - g)) >= dv_q[g].w;
      tv[g]  = (dv_q[g].rv >> (QW - 1 - g)) >= dv_q[g].w;
      dv_d[g+1]    = dv_q[g];
      dv_d[g+1].ru = tu[g] ? dv_q[g].ru - dsh[g] : dv_q[g].ru;
      dv_d[g+1].rv = tv[g] ? dv_q[g].rv - dsh[g] : dv_q[g].rv;
      dv_d[g+1].qu[QW-1-g] = tu[g];
      dv_d[g+1].qv[QW-1-g] = tv[g];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int g = 0; g <= QW; g++) dv_q[g] <= '0;
    end else if (adv) begin
      for (int g = 0; g <= QW; g++) dv_q[g] <= dv_d[g];
    end
  end

  // ---------------- range check and image read ----------------
  dv_t           dl;
  logic          rng_ok;
  logic [QW:0]   uhi_w, uhi_h, mg;
  assign dl    = dv_q[QW];
  assign mg    = (QW+1)'(margin_q);
  assign uhi_w = (QW+1)'(width_q) - mg;
  assign uhi_h = (QW+1)'(height_q) - mg;

  // A negative nonzero quotient is below any margin; zero passes only at margin zero.
  logic ucn, vcn;
  assign ucn = dl.nu && (dl.qu != '0);
  assign vcn = dl.nv && (dl.qv != '0);

  always_comb begin
    rng_ok = !dl.big && !ucn && !vcn &&
             ({1'b0, dl.qu} >= mg) && ({1'b0, dl.qv} >= mg) &&
             (mg <= (QW+1)'(width_q)) && (mg <= (QW+1)'(height_q)) &&
             ({1'b0, dl.qu} <= uhi_w) && ({1'b0, dl.qv} <= uhi_h) &&
             ({1'b0, dl.qu} < (QW+1)'(width_q)) && ({1'b0, dl.qv} < (QW+1)'(height_q)) &&
             ({1'b0, dl.qu} < (QW+1)'(MAX_WIDTH)) && ({1'b0, dl.qv} < (QW+1)'(MAX_HEIGHT));
  end

  logic [23:0]     img_mem [MAX_WIDTH*MAX_HEIGHT];
  logic [23:0]     rd_q;
  logic [PIX_AW-1:0] rd_a;
  assign rd_a  = {dl.qv[ROW_W-1:0], dl.qu[COL_W-1:0]};

  always_ff @(posedge clk_i) begin
    if (adv && dl.pw) img_mem[dl.pa] <= dl.rgb;
  end

  always_ff @(posedge clk_i) begin
    if (adv) rd_q <= img_mem[rd_a];
  end

  // ---------------- output stage ----------------
  logic        o_v_q;
  point_t      o_pt_q;
  logic [9:0]  o_col_q, o_row_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) o_v_q <= 1'b0;
    else if (adv) o_v_q <= dl.v && rng_ok;
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      o_pt_q  <= dl.pt;
      o_col_q <= 10'(dl.qu);
      o_row_q <= 10'(dl.qv);
    end
  end

  assign last_v      = o_v_q;
  assign out_valid_o = o_v_q;
  assign out_x_o     = o_pt_q.x;
  assign out_y_o     = o_pt_q.y;
  assign out_z_o     = o_pt_q.z;
  assign red_o       = rd_q[23:16];
  assign green_o     = rd_q[15:8];
  assign blue_o      = rd_q[7:0];
  assign image_col_o = o_col_q;
  assign image_row_o = o_row_q;

`ifndef ASSERT_OFF
  a_stall_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_x_o) && $stable(red_o))
    else $error("output beat changed while stalled");
  a_ready_follows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !out_valid_o |-> in_ready_o)
    else $error("input blocked with empty output");
  a_col_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> ({1'b0, image_col_o} < width_q) && ({1'b0, image_row_o} < height_q))
    else $error("emitted pixel outside image");
`endif

endmodule
